@@ src/rrcc_pkg.sv @@
`default_nettype none

package rrcc_pkg;

  localparam int unsigned MAX_ELEM_W = 16;
  localparam logic [MAX_ELEM_W-1:0] MAX_ELEMENTS_RESET = 16'd1024;

  typedef enum logic [1:0] {
    VERDICT_COMPLETE  = 2'd0,
    VERDICT_NEED_MORE = 2'd1,
    VERDICT_ERROR     = 2'd2
  } verdict_e;

  typedef enum logic [2:0] {
    KIND_STATUS  = 3'd0,
    KIND_ERROR   = 3'd1,
    KIND_INTEGER = 3'd2,
    KIND_BULK    = 3'd3,
    KIND_MULTI   = 3'd4,
    KIND_UNKNOWN = 3'd5
  } kind_e;

  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

endpackage

`default_nettype wire

@@ src/rrcc_in_if.sv @@
`default_nettype none

interface rrcc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

@@ src/rrcc_out_if.sv @@
`default_nettype none

interface rrcc_out_if;
  import rrcc_pkg::*;

  logic     valid;
  logic     ready;
  verdict_e verdict;
  kind_e    reply_kind;

  modport source (output valid, output verdict, output reply_kind, input ready);
  modport sink   (input valid, input verdict, input reply_kind, output ready);
endinterface

`default_nettype wire

@@ src/resp_reply_completeness_check_core.sv @@
// reply completeness checker for a line-based key/value reply stream
// in_if: one reply byte per transfer, last_byte marks the end of the buffer so far
// out_if: one verdict and reply kind per buffer, given only for a last byte
// cfg_we_i/cfg_wdata_i: write max_elements, the largest multi-bulk count accepted
// a byte goes through an input register, then one pass of parse logic into the
// parser state and the result register
// throughput: one byte per cycle unless a last byte waits on a stalled result, bytes of any buffer back to back
// a stalled result holds out_if; bytes that are not last keep flowing, a last
// byte waits in the input register until the result register frees, and
// in_if.ready is low only while it waits
// reset clears the parser to await a type byte and sets max_elements to 1024
// number fields hold LENGTH_BITS bits and saturate; a length or count line
// longer than MAX_DIGIT_FIELD bytes is flagged as an error
`default_nettype none

module resp_reply_completeness_check_core #(
  parameter int unsigned LENGTH_BITS     = 32,
  parameter int unsigned MAX_DIGIT_FIELD = 10
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  rrcc_in_if.sink                                in_if,
  rrcc_out_if.source                             out_if,
  input  wire logic                              cfg_we_i,
  input  wire logic [rrcc_pkg::MAX_ELEM_W-1:0]   cfg_wdata_i
);
  import rrcc_pkg::*;

  localparam int unsigned DCNT_W = $clog2(MAX_DIGIT_FIELD + 3);
  localparam logic [DCNT_W-1:0] DCNT_SAT   = DCNT_W'(MAX_DIGIT_FIELD + 2);
  localparam logic [DCNT_W-1:0] DCNT_LIMIT = DCNT_W'(MAX_DIGIT_FIELD + 1);
  localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;
  localparam logic [LENGTH_BITS-1:0] LEN_TWO = LENGTH_BITS'(2);

  typedef enum logic [2:0] {
    PH_TYPE,
    PH_HEADER,
    PH_EHEADER,
    PH_SKIP,
    PH_ELEM,
    PH_DONE,
    PH_ERR
  } phase_e;

  // input register
  logic       a_valid_q, a_valid_d;
  logic [7:0] a_data_q, a_data_d;
  logic       a_last_q, a_last_d;

  // parser state
  phase_e                  phase_q, phase_d;
  kind_e                   kind_q, kind_d;
  logic [1:0]              bcnt_q, bcnt_d;
  logic                    cr_q, cr_d;
  logic [LENGTH_BITS-1:0]  accum_q, accum_d;
  logic                    neg_q, neg_d;
  logic                    stop_q, stop_d;
  logic                    begun_q, begun_d;
  logic [DCNT_W-1:0]       dcnt_q, dcnt_d;
  logic [LENGTH_BITS-1:0]  skip_q, skip_d;
  logic [MAX_ELEM_W-1:0]   elem_q, elem_d;
  logic [MAX_ELEM_W-1:0]   max_elem_q, max_elem_d;

  // result register
  logic     out_valid_q, out_valid_d;
  verdict_e verdict_q, verdict_d;
  kind_e    kind_out_q, kind_out_d;

  logic                    out_free;
  logic                    a_fire;
  logic                    in_ready;
  logic [7:0]              c;
  logic                    crlf;
  logic                    c_ws;
  logic                    c_sign;
  logic                    c_dig;
  logic [3:0]              digit;
  logic                    stop_eff;
  logic [LENGTH_BITS+3:0]  acc_ext;
  logic [LENGTH_BITS+3:0]  mac_wide;
  logic [LENGTH_BITS-1:0]  mac_sat;
  logic [LENGTH_BITS-1:0]  skip_dec;
  logic [MAX_ELEM_W-1:0]   elem_dec;
  phase_e                  end_elem_phase;
  logic                    is_line_kind;

  assign out_free = !out_valid_q || out_if.ready;
  assign a_fire   = a_valid_q && (!a_last_q || out_free);
  assign in_ready = !a_valid_q || a_fire;

  assign in_if.ready       = in_ready;
  assign out_if.valid      = out_valid_q;
  assign out_if.verdict    = verdict_q;
  assign out_if.reply_kind = kind_out_q;

  assign c      = a_data_q;
  assign crlf   = cr_q && (c == CH_LF);
  assign c_ws   = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  assign c_sign = (c == CH_PLUS) || (c == CH_MINUS);
  assign c_dig  = (c >= CH_ZERO) && (c <= CH_NINE);
  assign digit  = 4'(c - CH_ZERO);

  // a lone cr seen earlier ends a begun number
  assign stop_eff = stop_q || (cr_q && begun_q);

  // accum * 10 + digit, saturating
  assign acc_ext  = {4'b0000, accum_q};
  assign mac_wide = (acc_ext << 3) + (acc_ext << 1) + {{LENGTH_BITS{1'b0}}, digit};
  assign mac_sat  = (mac_wide > {4'b0000, LEN_MAX}) ? LEN_MAX : mac_wide[LENGTH_BITS-1:0];

  assign skip_dec = (skip_q != '0) ? skip_q - LENGTH_BITS'(1) : skip_q;
  assign elem_dec = (elem_q != '0) ? elem_q - MAX_ELEM_W'(1) : elem_q;
  assign end_elem_phase = ((kind_q == KIND_BULK) || (elem_dec == '0)) ? PH_DONE : PH_ELEM;
  assign is_line_kind = (kind_q == KIND_STATUS) || (kind_q == KIND_ERROR) ||
                        (kind_q == KIND_INTEGER);

  always_comb begin
    a_valid_d   = a_valid_q;
    a_data_d    = a_data_q;
    a_last_d    = a_last_q;
    phase_d     = phase_q;
    kind_d      = kind_q;
    bcnt_d      = bcnt_q;
    cr_d        = cr_q;
    accum_d     = accum_q;
    neg_d       = neg_q;
    stop_d      = stop_q;
    begun_d     = begun_q;
    dcnt_d      = dcnt_q;
    skip_d      = skip_q;
    elem_d      = elem_q;
    max_elem_d  = cfg_we_i ? cfg_wdata_i : max_elem_q;
    out_valid_d = out_valid_q && !out_if.ready;
    verdict_d   = verdict_q;
    kind_out_d  = kind_out_q;

    if (in_ready) begin
      a_valid_d = in_if.valid;
      if (in_if.valid) begin
        a_data_d = in_if.data_byte;
        a_last_d = in_if.last_byte;
      end
    end

    if (a_fire) begin
      bcnt_d = (bcnt_q == 2'd3) ? bcnt_q : bcnt_q + 2'd1;

      unique case (phase_q)
        PH_TYPE: begin
          unique case (c)
            CH_PLUS:   kind_d = KIND_STATUS;
            CH_MINUS:  kind_d = KIND_ERROR;
            CH_COLON:  kind_d = KIND_INTEGER;
            CH_DOLLAR: kind_d = KIND_BULK;
            CH_STAR:   kind_d = KIND_MULTI;
            default:   kind_d = KIND_UNKNOWN;
          endcase
          if (kind_d == KIND_UNKNOWN) begin
            phase_d = PH_ERR;
          end else begin
            accum_d = '0;
            neg_d   = 1'b0;
            stop_d  = 1'b0;
            begun_d = 1'b0;
            dcnt_d  = '0;
            phase_d = PH_HEADER;
          end
        end
        PH_HEADER, PH_EHEADER: begin
          if (crlf) begin
            if (is_line_kind) begin
              phase_d = PH_DONE;
            end else if (dcnt_q > DCNT_LIMIT) begin
              phase_d = PH_ERR;
            end else if ((kind_q == KIND_MULTI) && (phase_q == PH_HEADER)) begin
              if ((neg_q && (accum_q != '0)) ||
                  (accum_q > LENGTH_BITS'(max_elem_q))) begin
                phase_d = PH_ERR;
              end else begin
                elem_d  = accum_q[MAX_ELEM_W-1:0];
                phase_d = (accum_q[MAX_ELEM_W-1:0] == '0) ? PH_DONE : PH_ELEM;
              end
            end else if (neg_q && (accum_q == LENGTH_BITS'(1))) begin
              // null bulk
              phase_d = end_elem_phase;
              if (kind_q != KIND_BULK) begin
                elem_d = elem_dec;
              end
            end else if (neg_q && (accum_q != '0)) begin
              phase_d = PH_ERR;
            end else begin
              if (neg_q) begin
                skip_d = LEN_TWO;
              end else if (accum_q > (LEN_MAX - LEN_TWO)) begin
                skip_d = LEN_MAX;
              end else begin
                skip_d = accum_q + LEN_TWO;
              end
              phase_d = PH_SKIP;
            end
          end else begin
            if (dcnt_q < DCNT_SAT) begin
              dcnt_d = dcnt_q + DCNT_W'(1);
            end
            stop_d = stop_eff;
            if ((c != CH_CR) && !stop_eff) begin
              if (!begun_q && c_ws) begin
                stop_d = stop_eff;
              end else if (!begun_q && c_sign) begin
                begun_d = 1'b1;
                neg_d   = (c == CH_MINUS);
              end else if (c_dig) begin
                begun_d = 1'b1;
                accum_d = mac_sat;
              end else begin
                stop_d = 1'b1;
              end
            end
          end
        end
        PH_SKIP: begin
          skip_d = skip_dec;
          if (skip_dec == '0) begin
            phase_d = end_elem_phase;
            if (kind_q != KIND_BULK) begin
              elem_d = elem_dec;
            end
          end
        end
        PH_ELEM: begin
          if (c == CH_DOLLAR) begin
            accum_d = '0;
            neg_d   = 1'b0;
            stop_d  = 1'b0;
            begun_d = 1'b0;
            dcnt_d  = '0;
            phase_d = PH_EHEADER;
          end else begin
            phase_d = PH_ERR;
          end
        end
        PH_DONE: phase_d = PH_ERR;
        PH_ERR:  phase_d = PH_ERR;
        default: phase_d = PH_ERR;
      endcase

      cr_d = (c == CH_CR);

      if (a_last_q) begin
        out_valid_d = 1'b1;
        kind_out_d  = kind_d;
        if (kind_d == KIND_UNKNOWN) begin
          verdict_d = VERDICT_ERROR;
        end else if ((bcnt_d != 2'd3) || !crlf) begin
          verdict_d = VERDICT_NEED_MORE;
        end else if (phase_d == PH_ERR) begin
          verdict_d = VERDICT_ERROR;
        end else if (phase_d == PH_DONE) begin
          verdict_d = VERDICT_COMPLETE;
        end else begin
          verdict_d = VERDICT_NEED_MORE;
        end
        // clear per-buffer state
        phase_d = PH_TYPE;
        kind_d  = KIND_STATUS;
        bcnt_d  = 2'd0;
        cr_d    = 1'b0;
        accum_d = '0;
        neg_d   = 1'b0;
        stop_d  = 1'b0;
        begun_d = 1'b0;
        dcnt_d  = '0;
        skip_d  = '0;
        elem_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      a_data_q    <= '0;
      a_last_q    <= 1'b0;
      phase_q     <= PH_TYPE;
      kind_q      <= KIND_STATUS;
      bcnt_q      <= 2'd0;
      cr_q        <= 1'b0;
      accum_q     <= '0;
      neg_q       <= 1'b0;
      stop_q      <= 1'b0;
      begun_q     <= 1'b0;
      dcnt_q      <= '0;
      skip_q      <= '0;
      elem_q      <= '0;
      max_elem_q  <= MAX_ELEMENTS_RESET;
      out_valid_q <= 1'b0;
      verdict_q   <= VERDICT_COMPLETE;
      kind_out_q  <= KIND_STATUS;
    end else begin
      a_valid_q   <= a_valid_d;
      a_data_q    <= a_data_d;
      a_last_q    <= a_last_d;
      phase_q     <= phase_d;
      kind_q      <= kind_d;
      bcnt_q      <= bcnt_d;
      cr_q        <= cr_d;
      accum_q     <= accum_d;
      neg_q       <= neg_d;
      stop_q      <= stop_d;
      begun_q     <= begun_d;
      dcnt_q      <= dcnt_d;
      skip_q      <= skip_d;
      elem_q      <= elem_d;
      max_elem_q  <= max_elem_d;
      out_valid_q <= out_valid_d;
      verdict_q   <= verdict_d;
      kind_out_q  <= kind_out_d;
    end
  end

endmodule

`default_nettype wire

@@ src/rrcc_checker.sv @@
`default_nettype none

module rrcc_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [1:0] verdict_i,
  input wire logic [2:0] reply_kind_i
);
  import rrcc_pkg::*;

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(verdict_i) &&
                                    $stable(reply_kind_i))
    else $error("result changed while stalled");

  a_verdict_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (verdict_i == VERDICT_COMPLETE) || (verdict_i == VERDICT_NEED_MORE) ||
                    (verdict_i == VERDICT_ERROR))
    else $error("verdict code out of range");

  a_unknown_is_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (reply_kind_i == KIND_UNKNOWN) |-> verdict_i == VERDICT_ERROR)
    else $error("unknown reply kind without error verdict");

  // input backpressure only when the result register is stalled
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled with result register free");

endmodule

bind resp_reply_completeness_check_core rrcc_checker u_rrcc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_if.valid),
  .in_ready_i   (in_if.ready),
  .out_valid_i  (out_if.valid),
  .out_ready_i  (out_if.ready),
  .verdict_i    (out_if.verdict),
  .reply_kind_i (out_if.reply_kind)
);

`default_nettype wire

@@ test/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rrcc_pkg::*;

  localparam int unsigned NUM_W = 32;
  localparam int unsigned MAX_FIELD = 10;
  localparam logic [NUM_W-1:0] NUM_SAT = '1;
  localparam int QUIET_LIMIT = 5000;

  typedef enum logic [2:0] {
    PS_TYPE, PS_HEADER, PS_EHEADER, PS_SKIP, PS_ELEM, PS_DONE, PS_ERR
  } parse_state_e;

  typedef struct {
    logic [7:0] octet;
    bit         is_last;
  } byte_xfer_t;

  typedef struct {
    verdict_e verdict;
    kind_e    kind;
  } reply_check_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  rrcc_in_if  byte_ch ();
  rrcc_out_if verdict_ch ();

  resp_reply_completeness_check_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_if       (byte_ch),
    .out_if      (verdict_ch),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  always #4 clk = ~clk;

  byte_xfer_t   reply_bytes_q[$];
  reply_check_t verdicts_due_q[$];
  logic [7:0]   reply_buf[$];
  int unsigned  queued_bytes = 0;
  int unsigned  outstanding_bytes = 0;
  int           idle_pct = 0;
  int           stall_pct = 0;
  int           err_count = 0;
  int           quiet_cycles = 0;

  // parser shadow state
  logic [15:0]      max_elem_q;
  logic [31:0]      rp_count;
  kind_e            rp_kind;
  parse_state_e     rp_state;
  bit               rp_prev_cr;
  logic [NUM_W-1:0] rp_num;
  bit               rp_neg;
  bit               rp_stop;
  bit               rp_begun;
  logic [3:0]       rp_field_len;
  logic [NUM_W-1:0] rp_skip;
  logic [15:0]      rp_elems;
  bit               rp_done;
  bit               rp_err;

  function automatic void clear_reply();
    rp_count = '0;
    rp_kind = KIND_STATUS;
    rp_state = PS_TYPE;
    rp_prev_cr = 0;
    rp_num = '0;
    rp_neg = 0;
    rp_stop = 0;
    rp_begun = 0;
    rp_field_len = '0;
    rp_skip = '0;
    rp_elems = '0;
    rp_done = 0;
    rp_err = 0;
  endfunction

  function automatic void begin_number(parse_state_e nxt);
    rp_num = '0;
    rp_neg = 0;
    rp_stop = 0;
    rp_begun = 0;
    rp_field_len = '0;
    rp_state = nxt;
  endfunction

  function automatic void mark_error();
    rp_err = 1;
    rp_state = PS_ERR;
  endfunction

  function automatic void mark_done();
    rp_done = 1;
    rp_state = PS_DONE;
  endfunction

  function automatic void feed_number(logic [7:0] c);
    logic [NUM_W-1:0] d;
    if (rp_stop) return;
    if (!rp_begun) begin
      if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) return;
      if (c == CH_PLUS || c == CH_MINUS) begin
        rp_begun = 1;
        rp_neg = (c == CH_MINUS);
        return;
      end
    end
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = NUM_W'(c - CH_ZERO);
      rp_begun = 1;
      if (rp_num > (NUM_SAT - d) / 10) rp_num = NUM_SAT;
      else rp_num = rp_num * 10 + d;
    end else begin
      rp_stop = 1;
    end
  endfunction

  function automatic void close_element();
    if (rp_kind == KIND_BULK) begin
      mark_done();
      return;
    end
    if (rp_elems > 0) rp_elems--;
    if (rp_elems == 0) mark_done();
    else rp_state = PS_ELEM;
  endfunction

  task automatic parse_reply_byte(input logic [7:0] c, input bit is_last, output bit has_res,
                                  output reply_check_t res);
    bit         was_cr;
    logic [7:0] field_len;
    was_cr = rp_prev_cr;
    has_res = 0;
    res.verdict = VERDICT_COMPLETE;
    res.kind = KIND_STATUS;
    if (rp_count != '1) rp_count++;
    case (rp_state)
      PS_TYPE: begin
        case (c)
          CH_PLUS:   rp_kind = KIND_STATUS;
          CH_MINUS:  rp_kind = KIND_ERROR;
          CH_COLON:  rp_kind = KIND_INTEGER;
          CH_DOLLAR: rp_kind = KIND_BULK;
          CH_STAR:   rp_kind = KIND_MULTI;
          default:   rp_kind = KIND_UNKNOWN;
        endcase
        if (rp_kind == KIND_UNKNOWN) mark_error();
        else begin_number(PS_HEADER);
      end
      PS_HEADER, PS_EHEADER: begin
        if (was_cr && c == CH_LF) begin
          field_len = {4'd0, rp_field_len} - 8'd1;
          if (rp_kind <= KIND_INTEGER) begin
            mark_done();
          end else if (field_len > MAX_FIELD) begin
            mark_error();
          end else if (rp_kind == KIND_MULTI && rp_state == PS_HEADER) begin
            if ((rp_neg && rp_num != 0) || rp_num > NUM_W'(max_elem_q)) begin
              mark_error();
            end else begin
              rp_elems = rp_num[15:0];
              if (rp_elems == 0) mark_done();
              else rp_state = PS_ELEM;
            end
          end else if (rp_neg && rp_num == 1) begin
            close_element();
          end else if (rp_neg && rp_num != 0) begin
            mark_error();
          end else begin
            if (rp_neg) rp_skip = 2;
            else if (rp_num > NUM_SAT - 2) rp_skip = NUM_SAT;
            else rp_skip = rp_num + 2;
            rp_state = PS_SKIP;
          end
        end else begin
          if (rp_field_len < 4'(MAX_FIELD + 2)) rp_field_len++;
          if (was_cr) feed_number(CH_CR);
          if (c != CH_CR) feed_number(c);
        end
      end
      PS_SKIP: begin
        if (rp_skip > 0) rp_skip--;
        if (rp_skip == 0) close_element();
      end
      PS_ELEM: begin
        if (c == CH_DOLLAR) begin_number(PS_EHEADER);
        else mark_error();
      end
      PS_DONE: mark_error();
      default: ;
    endcase
    rp_prev_cr = (c == CH_CR);
    if (is_last) begin
      has_res = 1;
      res.kind = rp_kind;
      if (rp_kind == KIND_UNKNOWN) res.verdict = VERDICT_ERROR;
      else if (rp_count < 3 || !(was_cr && c == CH_LF)) res.verdict = VERDICT_NEED_MORE;
      else if (rp_err) res.verdict = VERDICT_ERROR;
      else if (rp_done) res.verdict = VERDICT_COMPLETE;
      else res.verdict = VERDICT_NEED_MORE;
      clear_reply();
    end
  endtask

  // stimulus building
  function automatic void add_line(string s, bit crlf = 1);
    for (int i = 0; i < s.len(); i++) reply_buf.push_back(s[i]);
    if (crlf) begin
      reply_buf.push_back(CH_CR);
      reply_buf.push_back(CH_LF);
    end
  endfunction

  function automatic void push_frame();
    byte_xfer_t x;
    foreach (reply_buf[i]) begin
      x.octet = reply_buf[i];
      x.is_last = (i == reply_buf.size() - 1);
      reply_bytes_q.push_back(x);
    end
    queued_bytes += reply_buf.size();
    outstanding_bytes += reply_buf.size();
    reply_buf.delete();
  endfunction

  function automatic void add_bulk(int unsigned max_len);
    int unsigned len;
    if ($urandom_range(9) == 0) begin
      add_line("$-1");
      return;
    end
    len = $urandom_range(max_len);
    case ($urandom_range(5))
      0: add_line($sformatf("$ %0d", len));
      1: add_line($sformatf("$+%0d", len));
      default: add_line($sformatf("$%0d", len));
    endcase
    repeat (len) reply_buf.push_back(8'($urandom));
    add_line("");
  endfunction

  function automatic void add_reply();
    int unsigned n;
    logic [7:0]  b;
    logic [7:0]  prev;
    case ($urandom_range(4))
      0, 1, 2: begin
        case ($urandom_range(2))
          0: prev = CH_PLUS;
          1: prev = CH_MINUS;
          default: prev = CH_COLON;
        endcase
        reply_buf.push_back(prev);
        repeat ($urandom_range(6)) begin
          b = 8'($urandom);
          if (prev == CH_CR && b == CH_LF) b = CH_SPACE;
          reply_buf.push_back(b);
          prev = b;
        end
        add_line("");
      end
      3: add_bulk(6);
      default: begin
        n = (max_elem_q < 3) ? max_elem_q : 3;
        n = $urandom_range(n);
        add_line($sformatf("*%0d", n));
        repeat (n) add_bulk(4);
      end
    endcase
  endfunction

  function automatic void add_random_buffer();
    int unsigned r;
    int unsigned cut;
    int unsigned pos;
    r = $urandom_range(99);
    if (r < 55) begin
      add_reply();
    end else if (r < 70) begin
      // reply cut short
      add_reply();
      cut = $urandom_range(1, reply_buf.size() - 1);
      while (reply_buf.size() > cut) void'(reply_buf.pop_back());
    end else if (r < 78) begin
      // trailing bytes after a full reply
      add_reply();
      if ($urandom_range(1)) add_reply();
      else reply_buf.push_back(8'($urandom));
    end else if (r < 86) begin
      add_reply();
      pos = $urandom_range(reply_buf.size() - 1);
      reply_buf[pos] = 8'($urandom);
    end else if (r < 92) begin
      add_line($sformatf("*%0d", int'(max_elem_q) + $urandom_range(1)));
    end else if (r < 95) begin
      if ($urandom_range(1)) add_line("$4294967295");
      else add_line("$99999999999");
      add_line("x");
    end else begin
      repeat ($urandom_range(1, 8)) reply_buf.push_back(8'($urandom));
    end
    push_frame();
  endfunction

  // byte driver
  always @(posedge clk) begin : drive
    byte_xfer_t   nxt;
    reply_check_t res;
    bit           has_res;
    if (rst_n) begin
      if (byte_ch.valid && byte_ch.ready) begin
        parse_reply_byte(byte_ch.data_byte, byte_ch.last_byte, has_res, res);
        if (has_res) verdicts_due_q.push_back(res);
        outstanding_bytes--;
      end
      if (!byte_ch.valid || byte_ch.ready) begin
        if (reply_bytes_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
          nxt = reply_bytes_q.pop_front();
          byte_ch.valid <= 1'b1;
          byte_ch.data_byte <= nxt.octet;
          byte_ch.last_byte <= nxt.is_last;
        end else begin
          byte_ch.valid <= 1'b0;
        end
      end
    end
  end

  // verdict monitor
  always @(posedge clk) begin : observe
    reply_check_t want;
    if (rst_n) begin
      if (verdict_ch.valid && verdict_ch.ready) begin
        if (verdicts_due_q.size() == 0) begin
          $display("%0t: unexpected transfer, got verdict %0d kind %0d", $time,
                   verdict_ch.verdict, verdict_ch.reply_kind);
          err_count++;
        end else begin
          want = verdicts_due_q.pop_front();
          if (want.verdict != verdict_ch.verdict) begin
            $display("%0t: verdict expected %0d got %0d", $time, want.verdict,
                     verdict_ch.verdict);
            err_count++;
          end
          if (want.kind != verdict_ch.reply_kind) begin
            $display("%0t: reply_kind expected %0d got %0d", $time, want.kind,
                     verdict_ch.reply_kind);
            err_count++;
          end
        end
      end
      verdict_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (byte_ch.valid && byte_ch.ready) || (verdict_ch.valid && verdict_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic drain();
    while (outstanding_bytes != 0) @(posedge clk);
    while (verdicts_due_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_max_elements(input logic [15:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    max_elem_q = v;
  endtask

  task automatic run_random(input logic [15:0] max_elems, input int sender_idle,
                            input int receiver_stall);
    int unsigned target;
    write_max_elements(max_elems);
    idle_pct = sender_idle;
    stall_pct = receiver_stall;
    target = queued_bytes + 50;
    while (queued_bytes < target) add_random_buffer();
    drain();
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    byte_ch.valid = 1'b0;
    byte_ch.data_byte = '0;
    byte_ch.last_byte = 1'b0;
    verdict_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    max_elem_q = MAX_ELEMENTS_RESET;
    clear_reply();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    add_line("+OK");              push_frame();
    add_line("-ERR bad");         push_frame();
    add_line(":-42");             push_frame();
    add_line("$3"); add_line("foo"); push_frame();
    add_line("$-1");              push_frame();
    add_line("*3"); add_line("$1"); add_line("a"); add_line("$-1");
    add_line("$0"); add_line("");  push_frame();
    add_line("*0");               push_frame();
    add_line("!x");               push_frame();
    add_line("+O", 0);            push_frame();
    add_line("+OK"); add_line("+", 0); push_frame();
    add_line("+OK"); add_line("+X"); push_frame();
    add_line("$5"); add_line("ab"); push_frame();
    add_line("$-2");              push_frame();
    add_line("$-0"); add_line(""); push_frame();
    add_line("$12345678901"); add_line("x"); push_frame();
    add_line("*2"); add_line(":1"); push_frame();
    add_line("*-1");              push_frame();
    add_line("*1025");            push_frame();
    add_line("*1024");            push_frame();
    add_line("*2"); add_line("$1"); add_line("a"); push_frame();
    // leading space, plus sign and a zero byte in the data
    add_line("$ +3"); add_line("a", 0); reply_buf.push_back(8'h00); add_line("b");
    push_frame();
    // lone cr inside a status line
    add_line("+a", 0); reply_buf.push_back(CH_CR); add_line("b"); push_frame();
    add_line("$9999999999"); add_line("ab"); push_frame();
    add_line("$3x"); add_line("abc"); push_frame();
    add_line("$\t2"); add_line("hi"); push_frame();
    drain();

    run_random(16'd0, 79, 0);
    run_random(16'hFFFF, 0, 79);
    run_random(16'd3, 35, 35);
    run_random(16'($urandom_range(1, 6)), 0, 0);

    if (err_count == 0 && verdicts_due_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
